// File: rtl/abst_pkg.sv
// Shared types and constants for the array binary search tree.
// Used by abst_node_mem, array_binary_search_tree and its checker.
// No dependencies.
package abst_pkg;

  localparam int CAPACITY  = 1023;
  localparam int KEY_WIDTH = 16;
  localparam int IDX_W     = 10;
  localparam int COUNT_W   = 10;
  localparam int STATUS_W  = 3;
  localparam int REQ_W     = 2;

  // Output payload layout: slot, value, count from bit 0 up, padded to bytes.
  localparam int OUT_BITS  = IDX_W + KEY_WIDTH + COUNT_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_SEARCH = 2'd1,
    REQ_MIN    = 2'd2,
    REQ_MAX    = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_DUP      = 3'd1,
    STAT_NOTFOUND = 3'd2,
    STAT_EMPTY    = 3'd3,
    STAT_RANGE    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                 en;
    logic [IDX_W-1:0]     addr;
    logic [KEY_WIDTH-1:0] data;
  } mem_wr_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } mem_rd_t;

endpackage

// File: rtl/array_binary_search_tree.sv
// Top level of the array binary search tree: request sequencer and result register.
// Depends on abst_pkg and abst_node_mem.
//
// Keys live in an implicit array of 1023 slots: slot 0 is the root and the
// children of slot i are 2i+1 (smaller keys) and 2i+2 (larger keys). A slot
// holding the empty_marker register value is vacant. Requests on the slave
// stream are insert, search, read minimum and read maximum; each gives one
// result transaction with status, slot, value and key count. After reset the
// block sweeps the store to zero, one slot a cycle, and s_tready stays low
// during the sweep while configuration writes are still taken. A request
// walks down the tree with one node store read per level, up to 10 levels;
// the marker-key insert and the empty-tree read skip the walk and read no
// node. The single read port of the node store paces the walk.
// A finished result waits in the output register, and the next request is
// accepted while it waits.
// Write empty_marker only while no request is in flight.
module array_binary_search_tree (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [abst_pkg::KEY_WIDTH-1:0]    cfg_wr_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [abst_pkg::KEY_WIDTH-1:0]    s_tdata,   // key
  input  logic [abst_pkg::REQ_W-1:0]        s_tuser,   // req_type
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [abst_pkg::OUT_TDATA_W-1:0]  m_tdata,   // slot, value, count, zero pad
  output logic [abst_pkg::STATUS_W-1:0]     m_tuser    // status
);

  localparam logic [abst_pkg::IDX_W:0]     CAP_L   = (abst_pkg::IDX_W+1)'(abst_pkg::CAPACITY);
  localparam logic [abst_pkg::IDX_W-1:0]   LAST_IX = abst_pkg::IDX_W'(abst_pkg::CAPACITY - 1);
  localparam logic [abst_pkg::COUNT_W-1:0] CNT_MAX = '1;
  localparam int PAD_W = abst_pkg::OUT_TDATA_W - abst_pkg::OUT_BITS;

  abst_pkg::state_t               state, state_next;
  logic [abst_pkg::IDX_W-1:0]     clr_cnt, clr_cnt_next;
  logic [abst_pkg::KEY_WIDTH-1:0] marker;
  abst_pkg::req_t                 req, req_next;
  logic [abst_pkg::KEY_WIDTH-1:0] key, key_next;
  logic [abst_pkg::IDX_W-1:0]     idx, idx_next;
  logic [abst_pkg::IDX_W-1:0]     cur_slot, cur_slot_next;
  logic [abst_pkg::KEY_WIDTH-1:0] cur_val, cur_val_next;
  logic                           first, first_next;
  logic [abst_pkg::COUNT_W-1:0]   count, count_next;
  abst_pkg::status_t              res_status, res_status_next;
  logic [abst_pkg::IDX_W-1:0]     res_slot, res_slot_next;
  logic [abst_pkg::KEY_WIDTH-1:0] res_value, res_value_next;
  logic                           out_valid, out_valid_next;
  logic [abst_pkg::OUT_TDATA_W-1:0] out_data, out_data_next;
  logic [abst_pkg::STATUS_W-1:0]  out_user, out_user_next;

  abst_pkg::mem_wr_t              mem_wr;
  abst_pkg::mem_rd_t              mem_rd;
  logic [abst_pkg::KEY_WIDTH-1:0] rdata;

  logic                           vacant;
  logic                           go_left;
  logic [abst_pkg::IDX_W:0]       child;
  logic                           child_out;
  logic                           is_walk_key;
  abst_pkg::req_t                 in_req;

  abst_node_mem u_mem (
    .clk     (clk),
    .wr      (mem_wr),
    .rd      (mem_rd),
    .rd_data (rdata)
  );

  assign in_req = abst_pkg::req_t'(s_tuser);

  // Child of the node under test: minimum always goes left, maximum right,
  // insert and search follow the key compare.
  assign is_walk_key = (req == abst_pkg::REQ_INSERT) || (req == abst_pkg::REQ_SEARCH);
  assign vacant      = (rdata == marker);
  assign go_left     = (req == abst_pkg::REQ_MIN) || (is_walk_key && (key < rdata));
  assign child       = {idx, 1'b0} + (go_left ? (abst_pkg::IDX_W+1)'(1)
                                              : (abst_pkg::IDX_W+1)'(2));
  assign child_out   = (child >= CAP_L);

  assign s_tready = (state == abst_pkg::S_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tuser  = out_user;

  always_ff @(posedge clk) begin
    if (rst) begin
      marker <= '0;
    end else if (cfg_wr_en) begin
      marker <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= abst_pkg::S_CLEAR;
      clr_cnt   <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr_cnt   <= clr_cnt_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    req        <= req_next;
    key        <= key_next;
    idx        <= idx_next;
    cur_slot   <= cur_slot_next;
    cur_val    <= cur_val_next;
    first      <= first_next;
    res_status <= res_status_next;
    res_slot   <= res_slot_next;
    res_value  <= res_value_next;
    out_data   <= out_data_next;
    out_user   <= out_user_next;
  end

  always_comb begin
    state_next      = state;
    clr_cnt_next    = clr_cnt;
    req_next        = req;
    key_next        = key;
    idx_next        = idx;
    cur_slot_next   = cur_slot;
    cur_val_next    = cur_val;
    first_next      = first;
    count_next      = count;
    res_status_next = res_status;
    res_slot_next   = res_slot;
    res_value_next  = res_value;
    out_data_next   = out_data;
    out_user_next   = out_user;
    // Drop the shown result once taken; a load below overrides this.
    out_valid_next  = out_valid && !m_tready;
    mem_wr.en       = 1'b0;
    mem_wr.addr     = idx;
    mem_wr.data     = key;
    mem_rd.en       = 1'b0;
    mem_rd.addr     = idx;

    case (state)
      abst_pkg::S_CLEAR: begin
        // Sweep every slot back to the reset marker value.
        mem_wr.en    = 1'b1;
        mem_wr.addr  = clr_cnt;
        mem_wr.data  = '0;
        clr_cnt_next = clr_cnt + 1'b1;
        if (clr_cnt == LAST_IX) begin
          state_next = abst_pkg::S_IDLE;
        end
      end

      abst_pkg::S_IDLE: begin
        if (s_tvalid) begin
          req_next   = in_req;
          key_next   = s_tdata;
          idx_next   = '0;
          first_next = 1'b1;
          if ((in_req == abst_pkg::REQ_INSERT) && (s_tdata == marker)) begin
            res_status_next = abst_pkg::STAT_RANGE;
            res_slot_next   = '0;
            res_value_next  = '0;
            state_next      = abst_pkg::S_DONE;
          end else if (((in_req == abst_pkg::REQ_MIN) || (in_req == abst_pkg::REQ_MAX))
                       && (count == '0)) begin
            res_status_next = abst_pkg::STAT_EMPTY;
            res_slot_next   = '0;
            res_value_next  = '0;
            state_next      = abst_pkg::S_DONE;
          end else begin
            // Fetch the root; the walk starts next cycle.
            mem_rd.en   = 1'b1;
            mem_rd.addr = '0;
            state_next  = abst_pkg::S_WALK;
          end
        end
      end

      abst_pkg::S_WALK: begin
        if (is_walk_key) begin
          if (vacant) begin
            if (req == abst_pkg::REQ_INSERT) begin
              mem_wr.en       = 1'b1;
              count_next      = (count == CNT_MAX) ? count : count + 1'b1;
              res_status_next = abst_pkg::STAT_OK;
              res_slot_next   = idx;
              res_value_next  = key;
            end else begin
              res_status_next = abst_pkg::STAT_NOTFOUND;
              res_slot_next   = '0;
              res_value_next  = '0;
            end
            state_next = abst_pkg::S_DONE;
          end else if (key == rdata) begin
            res_status_next = (req == abst_pkg::REQ_INSERT) ? abst_pkg::STAT_DUP
                                                             : abst_pkg::STAT_OK;
            res_slot_next   = idx;
            res_value_next  = key;
            state_next      = abst_pkg::S_DONE;
          end else if (child_out) begin
            res_status_next = (req == abst_pkg::REQ_INSERT) ? abst_pkg::STAT_RANGE
                                                             : abst_pkg::STAT_NOTFOUND;
            res_slot_next   = '0;
            res_value_next  = '0;
            state_next      = abst_pkg::S_DONE;
          end else begin
            // Advance one level and fetch the child.
            idx_next    = child[abst_pkg::IDX_W-1:0];
            mem_rd.en   = 1'b1;
            mem_rd.addr = child[abst_pkg::IDX_W-1:0];
          end
        end else begin
          // Minimum / maximum: the root counts even if it reads as vacant.
          if (first || !vacant) begin
            cur_slot_next = idx;
            cur_val_next  = rdata;
            first_next    = 1'b0;
            if (child_out) begin
              res_status_next = abst_pkg::STAT_OK;
              res_slot_next   = idx;
              res_value_next  = rdata;
              state_next      = abst_pkg::S_DONE;
            end else begin
              idx_next    = child[abst_pkg::IDX_W-1:0];
              mem_rd.en   = 1'b1;
              mem_rd.addr = child[abst_pkg::IDX_W-1:0];
            end
          end else begin
            res_status_next = abst_pkg::STAT_OK;
            res_slot_next   = cur_slot;
            res_value_next  = cur_val;
            state_next      = abst_pkg::S_DONE;
          end
        end
      end

      abst_pkg::S_DONE: begin
        // Hold the result until the output register is free.
        if (!out_valid || m_tready) begin
          out_valid_next = 1'b1;
          out_data_next  = {{PAD_W{1'b0}}, count, res_value, res_slot};
          out_user_next  = res_status;
          state_next     = abst_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = abst_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/abst_node_mem.sv
// Node store of the tree: one write port, one read port with registered data.
// Depends on abst_pkg.
module abst_node_mem (
  input  logic                           clk,
  input  abst_pkg::mem_wr_t              wr,
  input  abst_pkg::mem_rd_t              rd,
  output logic [abst_pkg::KEY_WIDTH-1:0] rd_data
);

  logic [abst_pkg::KEY_WIDTH-1:0] mem [abst_pkg::CAPACITY];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

// File: rtl/abst_checker.sv
// Port-level checker for array_binary_search_tree, bound to the top level.
// Depends on abst_pkg.
module abst_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tready,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [abst_pkg::OUT_TDATA_W-1:0]  m_tdata,
  input logic [abst_pkg::STATUS_W-1:0]     m_tuser
);

  localparam int VAL_HI = abst_pkg::IDX_W + abst_pkg::KEY_WIDTH - 1;

  // A stalled result transaction holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // The store sweep after reset keeps the request side closed.
  a_clear_closed: assert property (@(posedge clk)
    rst |=> !s_tready)
    else $error("request accepted during store sweep");

  // Empty-tree and out-of-range results carry zero slot and value.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && ((m_tuser == abst_pkg::STAT_EMPTY) || (m_tuser == abst_pkg::STAT_RANGE))
    |-> (m_tdata[VAL_HI:0] == '0))
    else $error("nonzero slot or value on failed request");

  // A duplicate insert reports either a nonzero key count or slot 0, the root.
  a_dup_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == abst_pkg::STAT_DUP)
    |-> (m_tdata[abst_pkg::OUT_BITS-1:VAL_HI+1] != '0) ||
        (m_tdata[abst_pkg::IDX_W-1:0] == '0))
    else $error("duplicate reported below the root in an empty tree");

endmodule

bind array_binary_search_tree abst_checker u_abst_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
